FILE: rtl/two_run_merge_top_defines.svh
// assertion macros used by the rtl top
`ifndef TWO_RUN_MERGE_TOP_DEFINES_SVH
`define TWO_RUN_MERGE_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define TRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define TRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/trm_pkg.sv
package trm_pkg;

	// widths cover the whole supported range of the element limit (up to 64)
	localparam int CNT_W = 7;
	localparam int IDX_W = 6;
	localparam int DATA_W = 32;

	// one loaded block handed from the front to the back
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] last_first;
	} trm_cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_MERGE
	} trm_bk_state_t;

endpackage

FILE: rtl/two_run_merge_top.sv
// two-run merge: loads a block of signed 32-bit values made of two ascending runs
// and returns their stable merge (ties go to the first run).
// input channel: push/full queue; value, first_run_end, block_end per transaction.
//   block_end closes the block; first_run_end marks the first run's last element
//   (only the first mark counts; none means the whole block is the first run).
//   at most MAX_ELEMENTS elements are kept per block, further ones are dropped.
// result channel: empty/pop queue; merged_value, merged_last (set on the block's
//   final result). one result per stored element, oldest first.
// timing: one element is loaded per cycle while full is low. the merge starts once the
//   block_end transaction has passed the block queue and the back has taken it, and then
//   gives one result per cycle while pop keeps up. the store has two banks: the next
//   block loads while the previous one merges; full rises when both banks are taken,
//   until the merge of the older block finishes.
// stalls: with pop low the finished result waits in the output register and the
//   merge pauses; loading goes on into the free bank.
// reset: arst_n clears all control state at once; the block is empty and takes
//   a new block straight away. no clearing pass is needed.
`include "two_run_merge_top_defines.svh"

module two_run_merge_top #(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] value,
	input  logic               first_run_end,
	input  logic               block_end,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] merged_value,
	output logic               merged_last
);

	// one extra address bit selects the bank
	localparam int AW = $clog2(MAX_ELEMENTS) + 1;

	logic                       accept;
	logic                       we;
	logic [AW-1:0]              waddr;
	logic [trm_pkg::DATA_W-1:0] wdata;
	logic [AW-1:0]              raddr_a;
	logic [AW-1:0]              raddr_b;
	logic [trm_pkg::DATA_W-1:0] rdata_a;
	logic [trm_pkg::DATA_W-1:0] rdata_b;

	logic                       cmd_push;
	trm_pkg::trm_cmd_t          cmd_in;
	logic                       cmd_pop;
	logic                       cmd_valid;
	trm_pkg::trm_cmd_t          cmd_out;
	logic [1:0]                 q_count;
	logic                       busy;
	logic [1:0]                 in_use;
	logic                       out_valid;

	// banks held by the back: queued blocks plus the one being merged
	assign in_use = q_count + {1'b0, busy};
	assign full   = in_use[1];
	assign accept = push && !full;
	assign empty  = !out_valid;

	trm_ram #(
		.WIDTH (trm_pkg::DATA_W),
		.DEPTH (2 << $clog2(MAX_ELEMENTS))
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// front: load elements and track the run split
	trm_front #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.value         (value),
		.first_run_end (first_run_end),
		.block_end     (block_end),
		.we            (we),
		.waddr         (waddr),
		.wdata         (wdata),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	// short queue of loaded blocks awaiting merge
	trm_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.cmd_in  (cmd_in),
		.pop     (cmd_pop),
		.valid   (cmd_valid),
		.cmd_out (cmd_out),
		.count   (q_count)
	);

	// back: two-head merge feeding the output register
	trm_back #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.busy      (busy),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.pop       (pop),
		.out_valid (out_valid),
		.out_value (merged_value),
		.out_last  (merged_last)
	);

	// never more than two banks in flight
	`TRM_ASSERT_NOW(a_bank_limit, 1'b1, in_use != 2'd3, "more than two banks in use")
	// a full queue must not take another block
	`TRM_ASSERT_NOW(a_no_overfill, q_count == 2'd2, !cmd_push, "block queue overflow")
	// a closed block shows up in the queue or the back in the next cycle
	`TRM_ASSERT_NEXT(a_block_handed, cmd_push, in_use != 2'd0, "closed block lost")

endmodule

FILE: rtl/trm_ram.sv
module trm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: rtl/trm_front.sv
module trm_front #(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic signed [31:0]                value,
	input  logic                              first_run_end,
	input  logic                              block_end,
	output logic                              we,
	output logic [$clog2(MAX_ELEMENTS):0]     waddr,
	output logic [trm_pkg::DATA_W-1:0]        wdata,
	output logic                              cmd_push,
	output trm_pkg::trm_cmd_t                 cmd
);

	localparam int IW = $clog2(MAX_ELEMENTS);

	logic                      bank_q;
	logic [trm_pkg::CNT_W-1:0] fill_q;
	logic [trm_pkg::IDX_W-1:0] split_q;
	logic                      seen_q;

	logic                      stored;
	logic                      split_now;
	logic [trm_pkg::CNT_W-1:0] fill_n;
	logic [trm_pkg::IDX_W-1:0] split_n;
	logic                      seen_n;
	logic [trm_pkg::CNT_W-1:0] fill_m1;

	// elements beyond the store limit are dropped
	assign stored    = fill_q < trm_pkg::CNT_W'(MAX_ELEMENTS);
	assign split_now = stored && first_run_end && !seen_q;
	assign fill_n    = fill_q + trm_pkg::CNT_W'(stored);
	assign split_n   = split_now ? fill_q[trm_pkg::IDX_W-1:0] : split_q;
	assign seen_n    = seen_q | split_now;
	assign fill_m1   = fill_n - trm_pkg::CNT_W'(1);

	assign we    = accept && stored;
	assign waddr = {bank_q, fill_q[IW-1:0]};
	assign wdata = $unsigned(value);

	assign cmd_push        = accept && block_end;
	assign cmd.bank        = bank_q;
	assign cmd.count       = fill_n;
	assign cmd.last_first  = seen_n ? split_n : fill_m1[trm_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			fill_q  <= '0;
			split_q <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			if (block_end) begin
				bank_q  <= ~bank_q;
				fill_q  <= '0;
				split_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				fill_q  <= fill_n;
				split_q <= split_n;
				seen_q  <= seen_n;
			end
		end
	end

endmodule

FILE: rtl/trm_cmd_q.sv
module trm_cmd_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  trm_pkg::trm_cmd_t cmd_in,
	input  logic              pop,
	output logic              valid,
	output trm_pkg::trm_cmd_t cmd_out,
	output logic [1:0]        count
);

	trm_pkg::trm_cmd_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;

	assign valid   = cnt_q != 2'd0;
	assign cmd_out = slot_q[rd_ptr_q];
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/trm_back.sv
module trm_back #(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  trm_pkg::trm_cmd_t             cmd,
	output logic                          cmd_pop,
	output logic                          busy,
	output logic [$clog2(MAX_ELEMENTS):0] raddr_a,
	output logic [$clog2(MAX_ELEMENTS):0] raddr_b,
	input  logic [trm_pkg::DATA_W-1:0]    rdata_a,
	input  logic [trm_pkg::DATA_W-1:0]    rdata_b,
	input  logic                          pop,
	output logic                          out_valid,
	output logic signed [31:0]            out_value,
	output logic                          out_last
);

	localparam int IW = $clog2(MAX_ELEMENTS);

	trm_pkg::trm_bk_state_t    state_q, state_d;
	logic                      bank_q, bank_d;
	logic [trm_pkg::CNT_W-1:0] count_q, count_d;
	logic [trm_pkg::IDX_W-1:0] last_q, last_d;
	logic [trm_pkg::CNT_W-1:0] head_a_q, head_a_d;
	logic [trm_pkg::CNT_W-1:0] head_b_q, head_b_d;
	logic [trm_pkg::CNT_W-1:0] emit_q, emit_d;
	logic                      out_valid_q;
	logic [trm_pkg::DATA_W-1:0] out_value_q;
	logic                      out_last_q;

	logic                      advance;
	logic                      take_first;
	logic                      is_last;

	// tie goes to the first run, keeping the merge stable
	always_comb begin
		if (head_a_q > {1'b0, last_q}) begin
			take_first = 1'b0;
		end else if (head_b_q >= count_q) begin
			take_first = 1'b1;
		end else begin
			take_first = $signed(rdata_a) <= $signed(rdata_b);
		end
	end

	assign is_last = (emit_q + trm_pkg::CNT_W'(1)) == count_q;

	always_comb begin
		state_d  = state_q;
		bank_d   = bank_q;
		count_d  = count_q;
		last_d   = last_q;
		head_a_d = head_a_q;
		head_b_d = head_b_q;
		emit_d   = emit_q;
		cmd_pop  = 1'b0;
		advance  = 1'b0;
		unique case (state_q)
			trm_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop  = 1'b1;
					bank_d   = cmd.bank;
					count_d  = cmd.count;
					last_d   = cmd.last_first;
					head_a_d = '0;
					head_b_d = {1'b0, cmd.last_first} + trm_pkg::CNT_W'(1);
					emit_d   = '0;
					state_d  = trm_pkg::BK_MERGE;
				end
			end
			trm_pkg::BK_MERGE: begin
				if (!out_valid_q || pop) begin
					advance = 1'b1;
					if (take_first) begin
						head_a_d = head_a_q + trm_pkg::CNT_W'(1);
					end else begin
						head_b_d = head_b_q + trm_pkg::CNT_W'(1);
					end
					emit_d = emit_q + trm_pkg::CNT_W'(1);
					if (is_last) begin
						state_d = trm_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = trm_pkg::BK_IDLE;
			end
		endcase
	end

	// address the next heads so read data lines up with the head registers
	assign raddr_a = {bank_d, head_a_d[IW-1:0]};
	assign raddr_b = {bank_d, head_b_d[IW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trm_pkg::BK_IDLE;
			bank_q      <= 1'b0;
			count_q     <= '0;
			last_q      <= '0;
			head_a_q    <= '0;
			head_b_q    <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			bank_q   <= bank_d;
			count_q  <= count_d;
			last_q   <= last_d;
			head_a_q <= head_a_d;
			head_b_q <= head_b_d;
			emit_q   <= emit_d;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_value_q <= take_first ? rdata_a : rdata_b;
			out_last_q  <= is_last;
		end
	end

	assign busy      = state_q == trm_pkg::BK_MERGE;
	assign out_valid = out_valid_q;
	assign out_value = $signed(out_value_q);
	assign out_last  = out_last_q;

endmodule

FILE: verif/two_run_merge_checker.sv
module two_run_merge_checker #(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic signed [31:0] value,
	input  logic               first_run_end,
	input  logic               block_end,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [31:0] merged_value,
	input  logic               merged_last,
	output int                 mismatch_count,
	output int                 pending_results
);

	typedef struct {
		logic signed [31:0] data;
		logic               last;
	} merged_word_t;

	merged_word_t expected_merge[$];

	logic signed [31:0] element_store [MAX_ELEMENTS];
	int fill_count;
	int split_index;
	bit split_seen;

	initial begin
		mismatch_count = 0;
		pending_results = 0;
	end

	task automatic report_mismatch(string what, merged_word_t want);
		if (mismatch_count < 10)
			$display("merge mismatch (%s): expected value %0d last %0b, got value %0d last %0b",
				what, want.data, want.last, merged_value, merged_last);
		mismatch_count++;
	endtask

	// stores one element; on block end, queues the stable merge of the two runs
	task automatic load_element(logic signed [31:0] v, logic run_end, logic blk_end);
		int count;
		int last_first;
		int first_head;
		int second_head;
		bit take_first;
		merged_word_t word;
		if (fill_count < MAX_ELEMENTS) begin
			element_store[fill_count] = v;
			if (run_end && !split_seen) begin
				split_index = fill_count;
				split_seen = 1'b1;
			end
			fill_count++;
		end
		if (blk_end) begin
			count = fill_count;
			last_first = split_seen ? split_index : count - 1;
			first_head = 0;
			second_head = last_first + 1;
			for (int k = 0; k < count; k++) begin
				if (first_head > last_first)
					take_first = 1'b0;
				else if (second_head >= count)
					take_first = 1'b1;
				else
					take_first = element_store[first_head] <= element_store[second_head];
				if (take_first) begin
					word.data = element_store[first_head];
					first_head++;
				end else begin
					word.data = element_store[second_head];
					second_head++;
				end
				word.last = (k == count - 1);
				expected_merge.push_back(word);
			end
			fill_count = 0;
			split_index = 0;
			split_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		merged_word_t want;
		if (!arst_n) begin
			fill_count = 0;
			split_index = 0;
			split_seen = 1'b0;
			expected_merge.delete();
			pending_results = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_merge.size() == 0) begin
					want.data = 'x;
					want.last = 1'bx;
					report_mismatch("unexpected transaction", want);
				end else begin
					want = expected_merge.pop_front();
					if (merged_value !== want.data || merged_last !== want.last)
						report_mismatch("wrong field", want);
				end
			end
			if (push && !full)
				load_element(value, first_run_end, block_end);
			pending_results = expected_merge.size();
		end
	end

endmodule

FILE: verif/two_run_merge_top_test.sv
module two_run_merge_top_test;

	localparam int MAX_ELEMENTS = 32;
	// generous: long gaps on both sides, blocks up to six past the store size
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 350;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [31:0] value;
	logic               first_run_end;
	logic               block_end;
	logic               empty;
	logic               pop;
	logic signed [31:0] merged_value;
	logic               merged_last;

	int mismatch_count;
	int pending_results;
	int cycles;
	int items_loaded;

	// shared between the sender and the receiver processes
	bit no_idle;
	bit hold_off_req;

	two_run_merge_top #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value(value),
		.first_run_end(first_run_end),
		.block_end(block_end),
		.empty(empty),
		.pop(pop),
		.merged_value(merged_value),
		.merged_last(merged_last)
	);

	two_run_merge_checker #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) merge_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value(value),
		.first_run_end(first_run_end),
		.block_end(block_end),
		.empty(empty),
		.pop(pop),
		.merged_value(merged_value),
		.merged_last(merged_last),
		.mismatch_count(mismatch_count),
		.pending_results(pending_results)
	);

	// 8 time unit period
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly back to back, sometimes a short gap, rarely a long one
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offers one element and holds it until the block takes the transaction
	task automatic send_element(logic signed [31:0] v, logic run_end, logic blk_end);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		value <= v;
		first_run_end <= run_end;
		block_end <= blk_end;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (items_loaded >= 0)
			items_loaded++;
	endtask

	// start of an ascending run; narrow ranges give plenty of ties between runs
	function automatic longint run_start(bit narrow);
		if (narrow)
			return longint'(int'($urandom_range(0, 8)) - 4);
		if ($urandom_range(0, 7) == 0)
			return -64'sd2147483648;
		return longint'($signed($urandom)) >>> 1;
	endfunction

	// tidy blocks are two ascending runs with the split flagged once (or not at all);
	// untidy ones carry random values and random first-run flags
	task automatic send_block(int len, bit tidy);
		bit narrow;
		bit has_split;
		int split;
		longint cur;
		logic signed [31:0] v;
		logic run_end;
		narrow = ($urandom_range(0, 3) == 0);
		has_split = ($urandom_range(0, 9) != 0);
		split = $urandom_range(0, len - 1);
		cur = 0;
		for (int i = 0; i < len; i++) begin
			if (tidy) begin
				if (i == 0 || (has_split && i == split + 1))
					cur = run_start(narrow);
				else if (narrow)
					cur = cur + longint'($urandom_range(0, 2));
				else
					cur = cur + longint'($urandom_range(0, 1 << 27));
				if (cur > 64'sd2147483647)
					cur = 64'sd2147483647;
				v = cur[31:0];
				run_end = has_split && (i == split);
			end else begin
				v = $urandom;
				run_end = ($urandom_range(0, 4) == 0);
			end
			send_element(v, run_end, i == len - 1);
		end
	endtask

	// mostly short blocks, some up to the store size, a few that overflow it
	task automatic send_random_block();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 5)
			len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 6);
		else if (r < 15)
			len = $urandom_range(20, MAX_ELEMENTS);
		else
			len = $urandom_range(1, 12);
		send_block(len, $urandom_range(0, 99) < 85);
	endtask

	// stop offering, let the checker see the last transaction, then wait for the results
	task automatic wait_for_drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	// receiver: random pop gaps, plus one long hold-off when asked for
	initial begin
		int gap;
		pop = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_off_req) begin
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				gap = idle_cycles();
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("two_run_merge_top_test failed");
		$finish;
	end

	// stimulus and verdict
	initial begin
		no_idle = 1'b0;
		hold_off_req = 1'b0;
		items_loaded = 0;
		arst_n = 1'b0;
		push = 1'b0;
		value = '0;
		first_run_end = 1'b0;
		block_end = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element, most negative value, first-run end on the last element
		send_element(32'sh80000000, 1'b1, 1'b1);
		// tie across runs, first run must win; most positive value
		send_element(-32'sd5, 1'b0, 1'b0);
		send_element(32'sd7, 1'b1, 1'b0);
		send_element(-32'sd5, 1'b0, 1'b0);
		send_element(32'sh7fffffff, 1'b0, 1'b1);
		// no first-run end: load order comes back unchanged
		send_element(32'sd0, 1'b0, 1'b0);
		send_element(-32'sd1, 1'b0, 1'b0);
		send_element(32'sh7fffffff, 1'b0, 1'b0);
		send_element(32'sh80000000, 1'b0, 1'b1);
		// repeated first-run end: only the first mark splits the block
		send_element(32'sd1, 1'b1, 1'b0);
		send_element(32'sd2, 1'b1, 1'b0);
		send_element(32'sd0, 1'b1, 1'b1);
		// first-run end on the last of several: second run empty
		send_element(-32'sd3, 1'b0, 1'b0);
		send_element(32'sd4, 1'b0, 1'b0);
		send_element(32'sd9, 1'b1, 1'b1);
		// second run entirely below the first, with extremes
		send_element(32'sd10, 1'b0, 1'b0);
		send_element(32'sh7fffffff, 1'b1, 1'b0);
		send_element(32'sh80000000, 1'b0, 1'b0);
		send_element(-32'sd1, 1'b0, 1'b1);
		wait_for_drain();

		items_loaded = 0;
		while (items_loaded < RANDOM_ITEMS / 3)
			send_random_block();

		// receiver holds off while the sender keeps offering, so full has to rise
		hold_off_req = 1'b1;
		repeat (4) send_block(16, 1'b1);
		// sender pause until every expected transaction has come back
		wait_for_drain();

		// a stretch with no idling on either side
		no_idle = 1'b1;
		while (items_loaded < (2 * RANDOM_ITEMS) / 3)
			send_random_block();
		no_idle = 1'b0;
		wait_for_drain();

		while (items_loaded < RANDOM_ITEMS)
			send_random_block();

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("two_run_merge_top_test passed");
		else
			$display("two_run_merge_top_test failed");
		$finish;
	end

endmodule
